// ===== hw/rtl/fps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR pulse shaping filter package
// Shared constants, command codes and the control bundle of the tap cells.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int TAPS_DEF        = 81;
  localparam int OUT_DEPTH_DEF   = 11;
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int COEFF_BITS_DEF  = 12;

  localparam int OUT_BITS    = 16;
  localparam int DELAY_BITS  = 4;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 4'd1;

  localparam int SAT_HIGH    = 32767;
  localparam int SAT_LOW     = -32768;
  // The sum is divided by four, which is a shift by two with a correction.
  localparam int SCALE_SHIFT = 2;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_LOAD   = 1'b1
  } command_t;

  typedef struct packed {
    logic shift;
    logic coef_wr;
  } cell_ctrl_t;

  // Width of the coefficient index, never below seven bits.
  function automatic int index_bits(int taps);
    return (taps > 128) ? 8 : 7;
  endfunction

endpackage

// ===== hw/rtl/fps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one tap sample and one coefficient, passes its sample to the next
// cell and adds its product to the partial sum that travels down the row.
// ----------------------------------------------------------------------------
module fps_cell #(
  parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = fps_pkg::COEFF_BITS_DEF,
  parameter int ACC_BITS    = 28,
  parameter int IDX_BITS    = 7,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fps_pkg::cell_ctrl_t           ctrl,
  input  logic [IDX_BITS-1:0]           coeff_index,
  input  logic signed [COEFF_BITS-1:0]  coeff_value,
  input  logic signed [SAMPLE_BITS-1:0] tap_in,
  output logic signed [SAMPLE_BITS-1:0] tap_out,
  input  logic signed [ACC_BITS-1:0]    sum_in,
  input  logic                          tok_in,
  output logic signed [ACC_BITS-1:0]    sum_out,
  output logic                          tok_out
);

  logic signed [COEFF_BITS-1:0]            coeff;
  logic signed [SAMPLE_BITS+COEFF_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]              prod_ext;

  assign prod     = tap_out * coeff;
  assign prod_ext = ACC_BITS'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_out <= '0;
      coeff   <= '0;
      tok_out <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        tap_out <= tap_in;
      end
      if (ctrl.coef_wr && (coeff_index == IDX_BITS'(INDEX))) begin
        coeff <= coeff_value;
      end
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      sum_out <= sum_in + prod_ext;
    end
  end

endmodule

// ===== hw/rtl/fps_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR output stage
// Scales and saturates the finished sum, shifts it into the output delay
// line and registers the selected entry for the output channel.
// ----------------------------------------------------------------------------
module fps_out_stage #(
  parameter int OUT_DEPTH = fps_pkg::OUT_DEPTH_DEF,
  parameter int ACC_BITS  = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [ACC_BITS-1:0]          sum,
  input  logic                                sum_valid,
  input  logic [fps_pkg::DELAY_BITS-1:0]      out_delay,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fps_pkg::OUT_BITS-1:0] filtered,
  output logic                                retire
);

  localparam int SEL_BITS = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int EXT_BITS = (ACC_BITS > fps_pkg::OUT_BITS + 1) ? ACC_BITS
                                                              : fps_pkg::OUT_BITS + 1;
  localparam logic signed [ACC_BITS-1:0] ROUND =
    ACC_BITS'((1 << fps_pkg::SCALE_SHIFT) - 1);
  localparam logic signed [EXT_BITS-1:0] HIGH_EXT = EXT_BITS'(fps_pkg::SAT_HIGH);
  localparam logic signed [EXT_BITS-1:0] LOW_EXT  = EXT_BITS'(fps_pkg::SAT_LOW);

  logic signed [ACC_BITS-1:0]          acc_hold;
  logic                                hold_valid;
  logic signed [ACC_BITS-1:0]          biased;
  logic signed [ACC_BITS-1:0]          quot;
  logic signed [EXT_BITS-1:0]          quot_ext;
  logic signed [fps_pkg::OUT_BITS-1:0] sat;
  logic signed [fps_pkg::OUT_BITS-1:0] line [OUT_DEPTH];
  logic signed [fps_pkg::OUT_BITS-1:0] line_next [OUT_DEPTH];
  logic [SEL_BITS-1:0]                 sel;

  assign retire = hold_valid && (!out_valid || out_ready);

  // Negative sums get a bias before the shift so the quotient truncates
  // toward zero.
  always_comb begin
    biased   = acc_hold[ACC_BITS-1] ? (acc_hold + ROUND) : acc_hold;
    quot     = biased >>> fps_pkg::SCALE_SHIFT;
    quot_ext = EXT_BITS'(quot);
    if (quot_ext > HIGH_EXT) begin
      sat = fps_pkg::OUT_BITS'(fps_pkg::SAT_HIGH);
    end else if (quot_ext < LOW_EXT) begin
      sat = fps_pkg::OUT_BITS'(fps_pkg::SAT_LOW);
    end else begin
      sat = quot_ext[fps_pkg::OUT_BITS-1:0];
    end
  end

  always_comb begin
    line_next[0] = sat;
    for (int k = 1; k < OUT_DEPTH; k++) begin
      line_next[k] = line[k-1];
    end
  end

  // A delay beyond the line picks its oldest entry.
  always_comb begin
    if (int'(out_delay) >= OUT_DEPTH) begin
      sel = SEL_BITS'(OUT_DEPTH - 1);
    end else begin
      sel = SEL_BITS'(out_delay);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sum_valid) begin
      hold_valid <= 1'b1;
    end else if (retire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      acc_hold <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < OUT_DEPTH; k++) begin
        line[k] <= '0;
      end
    end else if (retire) begin
      out_valid <= 1'b1;
      for (int k = 0; k < OUT_DEPTH; k++) begin
        line[k] <= line_next[k];
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      filtered <= line_next[sel];
    end
  end

endmodule

// ===== hw/rtl/fir_pulse_shaping_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR pulse shaping filter core
// Direct-form FIR built from a row of tap cells, with scaling, saturation
// and a selectable output delay line.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries a command with its fields.
// A load request writes one coefficient, leaves in_ready high and gives no
// result; an index of TAPS or more is dropped. A filter request shifts the
// sample into the tap row and sends a partial sum down the cells, one cell
// per cycle. The sum is registered in each cell, held in the output stage
// and then registered for out_valid. in_ready stays low from the request
// until that result moves into the output register, so a new sample is
// taken only after the last one has passed the whole cell row.
// The output register holds a result while out_ready is low; the next
// request can be taken meanwhile, and its sum waits in the output stage.
// cfg_data sets the output delay on a cfg_valid request and is always
// ready. Reset clears taps, coefficients and the delay line, sets the
// output delay to one and empties the output register.
// ----------------------------------------------------------------------------
module fir_pulse_shaping_filter_core #(
  parameter int TAPS        = fps_pkg::TAPS_DEF,
  parameter int OUT_DEPTH   = fps_pkg::OUT_DEPTH_DEF,
  parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = fps_pkg::COEFF_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    command,
  input  logic signed [SAMPLE_BITS-1:0]           sample,
  input  logic [fps_pkg::index_bits(TAPS)-1:0]    coeff_index,
  input  logic signed [COEFF_BITS-1:0]            coeff_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [fps_pkg::OUT_BITS-1:0]     filtered,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [fps_pkg::DELAY_BITS-1:0]          cfg_data
);

  localparam int ACC_BITS = SAMPLE_BITS + COEFF_BITS + $clog2(TAPS) + 1;
  localparam int IDX_BITS = fps_pkg::index_bits(TAPS);

  logic                                 busy;
  logic                                 start;
  logic                                 accept;
  logic                                 retire;
  logic [fps_pkg::DELAY_BITS-1:0]       out_delay;
  fps_pkg::cell_ctrl_t                  ctrl;
  logic signed [SAMPLE_BITS-1:0]        tap_w [TAPS];
  logic signed [ACC_BITS-1:0]           sum_w [TAPS+1];
  logic                                 tok_w [TAPS+1];

  assign in_ready     = !busy;
  assign cfg_ready    = 1'b1;
  assign accept       = in_valid && in_ready;
  assign ctrl.shift   = accept && (command == fps_pkg::CMD_FILTER);
  assign ctrl.coef_wr = accept && (command == fps_pkg::CMD_LOAD);

  assign tap_w[0] = sample;
  assign sum_w[0] = '0;
  assign tok_w[0] = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_delay <= fps_pkg::DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_delay <= cfg_data;
    end
  end

  // The sum starts in the cycle after the shift so cell zero sees the new sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= ctrl.shift;
      if (ctrl.shift) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k < TAPS - 1) begin : g_mid
      fps_cell #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEFF_BITS (COEFF_BITS),
        .ACC_BITS   (ACC_BITS),
        .IDX_BITS   (IDX_BITS),
        .INDEX      (k)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .coeff_index(coeff_index),
        .coeff_value(coeff_value),
        .tap_in     (tap_w[k]),
        .tap_out    (tap_w[k+1]),
        .sum_in     (sum_w[k]),
        .tok_in     (tok_w[k]),
        .sum_out    (sum_w[k+1]),
        .tok_out    (tok_w[k+1])
      );
    end else begin : g_last
      fps_cell #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEFF_BITS (COEFF_BITS),
        .ACC_BITS   (ACC_BITS),
        .IDX_BITS   (IDX_BITS),
        .INDEX      (k)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .coeff_index(coeff_index),
        .coeff_value(coeff_value),
        .tap_in     (tap_w[k]),
        .tap_out    (),
        .sum_in     (sum_w[k]),
        .tok_in     (tok_w[k]),
        .sum_out    (sum_w[k+1]),
        .tok_out    (tok_w[k+1])
      );
    end
  end

  fps_out_stage #(
    .OUT_DEPTH(OUT_DEPTH),
    .ACC_BITS (ACC_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .sum      (sum_w[TAPS]),
    .sum_valid(tok_w[TAPS]),
    .out_delay(out_delay),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered (filtered),
    .retire   (retire)
  );

endmodule

// ===== hw/rtl/fps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR pulse shaping filter checker
// Port-level assertions on the request flow of the filter core.
// ----------------------------------------------------------------------------
module fps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [fps_pkg::OUT_BITS-1:0] filtered
);

  // Reset empties the output and opens the input.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("filter not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("stalled result changed");

  // A filter request occupies the tap row until its result moves into the output register.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == fps_pkg::CMD_FILTER) |=> !in_ready)
    else $error("input taken while a sum is in flight");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == fps_pkg::CMD_LOAD) |=> in_ready)
    else $error("coefficient load blocked the input");

  // A new result frees the input in the same cycle it appears.
  a_result_frees: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the filter is still busy");

endmodule

bind fir_pulse_shaping_filter_core fps_checker u_fps_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .command  (command),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .filtered (filtered)
);
